@@ src/ppm_pkg.sv @@
// ============================================================================
// ppm_pkg
// Shared types and codes for the piecewise parameter mapper.
// ============================================================================
package ppm_pkg;

    // Operation of the shared saturating adder
    typedef enum logic
    {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    // Request kinds carried on the input tuser
    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_G2L  = 2'd1;
    localparam logic [1:0] ACT_L2G  = 2'd2;

    // Result status codes carried on the output tuser
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // Register map
    localparam logic [1:0] REG_SEGMENT_COUNT = 2'd0;

    // Fixed field widths
    localparam int FIELD_BITS = 32;
    localparam int COUNT_BITS = 5;
    localparam int INDEX_BITS = 4;

endpackage

@@ src/piecewise_parameter_mapper_core.sv @@
// ============================================================================
// piecewise_parameter_mapper_core
// Maps parameters between a global domain and per-segment local domains.
// ============================================================================
// Usage:
//   Requests enter on the s_* stream; tuser is the action (load segment,
//   global to local, local to global). Software loads the segments it uses
//   and then writes segment_count over the APB port while the block is idle.
//   Every request gives one result on the m_* stream; tuser is the status.
// Sequencing:
//   A load or a request that ends at once (no segments, index out of
//   range, unused action) passes through S_OUT to the output register.
//   A global to local query walks the segments (up to MAX_SEGMENTS) until
//   its window is hit; a local to global query with index i walks segments
//   0 to i. The walk runs through the segment table (one write port, one
//   read port) and one shared saturating adder, two adder steps per segment.
//   One request is processed at a time; s_tready is high only when idle.
// Reset: clears segment_count, the sequencer and the output valid; segment
//   table contents are undefined until loaded.
// Stall: a finished result waits in the output register; the next request
//   is taken meanwhile, and its result waits until the register frees.
// ============================================================================
module piecewise_parameter_mapper_core
    import ppm_pkg::*;
#(
    parameter int MAX_SEGMENTS = 16,
    parameter int VALUE_BITS   = 32
)
(
    input  logic         clk,
    input  logic         rst_n,

    // Request stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // segment_index[3:0], param_value[35:4],
                                    // domain_start[67:36], domain_end[99:68], zero
    input  logic [1:0]   s_tuser,   // action[1:0]

    // Result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata,   // mapped_value[31:0], segment_number[35:32], zero
    output logic [1:0]   m_tuser,   // status[1:0]

    // Configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int W   = VALUE_BITS;
    localparam int EW  = (VALUE_BITS > FIELD_BITS) ? VALUE_BITS : FIELD_BITS;
    localparam int CLW = $clog2(MAX_SEGMENTS + 1);
    localparam int KW  = (CLW > COUNT_BITS) ? CLW : COUNT_BITS;
    localparam int AW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam logic [KW-1:0] MAX_K = KW'(MAX_SEGMENTS);

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_SPAN,
        S_SUM,
        S_DIFF,
        S_MAP,
        S_OUT
    } state_t;

    // Clamp a 32-bit field into the internal value range
    function automatic logic [W-1:0] clamp_in(input logic [FIELD_BITS-1:0] v);
        logic signed [EW-1:0] e;
        logic [EW-W:0]        hi;
        e  = EW'($signed(v));
        hi = e[EW-1:W-1];
        if ((&hi) || !(|hi))
            clamp_in = e[W-1:0];
        else
            clamp_in = e[EW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    endfunction

    // Clamp an internal value into the 32-bit output field
    function automatic logic [FIELD_BITS-1:0] clamp_out(input logic [W-1:0] v);
        logic signed [EW-1:0]   e;
        logic [EW-FIELD_BITS:0] hi;
        e  = EW'($signed(v));
        hi = e[EW-1:FIELD_BITS-1];
        if ((&hi) || !(|hi))
            clamp_out = e[FIELD_BITS-1:0];
        else
            clamp_out = e[EW-1] ? {1'b1, {(FIELD_BITS-1){1'b0}}}
                                : {1'b0, {(FIELD_BITS-1){1'b1}}};
    endfunction

    state_t                state_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [1:0]            act_reg;
    logic [KW-1:0]         idx_reg;
    logic [KW-1:0]         cnt_reg;
    logic [KW-1:0]         k_reg;
    logic [W-1:0]          param_reg;
    logic [W-1:0]          offset_reg;
    logic [W-1:0]          span_reg;
    logic [W-1:0]          start_reg;
    logic [W-1:0]          tmp_reg;
    logic [W-1:0]          res_mapped_reg;
    logic [INDEX_BITS-1:0] res_seg_reg;
    logic [1:0]            res_status_reg;
    logic                  out_valid_reg;
    logic [FIELD_BITS-1:0] out_mapped_reg;
    logic [INDEX_BITS-1:0] out_seg_reg;
    logic [1:0]            out_status_reg;

    logic [INDEX_BITS-1:0] in_index;
    logic [KW-1:0]         in_idx_k;
    logic [W-1:0]          in_param;
    logic [W-1:0]          in_start;
    logic [W-1:0]          in_end;
    logic [KW-1:0]         count_k;
    logic [KW-1:0]         active_cnt;
    logic [KW-1:0]         k_inc;
    logic                  accept;
    logic                  cfg_write;
    logic                  mem_we;
    logic [AW-1:0]         raddr;
    logic [W-1:0]          rstart;
    logic [W-1:0]          rend;
    alu_op_t               alu_op;
    logic [W-1:0]          alu_a;
    logic [W-1:0]          alu_b;
    logic [W-1:0]          alu_y;
    logic                  at_target;
    logic                  hit;

    // Unpack the request
    assign in_index = s_tdata[3:0];
    assign in_idx_k = KW'(in_index);
    assign in_param = clamp_in(s_tdata[35:4]);
    assign in_start = clamp_in(s_tdata[67:36]);
    assign in_end   = clamp_in(s_tdata[99:68]);

    // Active segment count, limited to the table depth
    assign count_k    = KW'(count_reg);
    assign active_cnt = (count_k > MAX_K) ? MAX_K : count_k;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign k_inc    = k_reg + KW'(1);
    assign mem_we   = accept && (s_tuser == ACT_LOAD) && (in_idx_k < MAX_K);

    // Read ahead the next segment while the current one is summed
    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  raddr = '0;
            S_SUM:   raddr = k_inc[AW-1:0];
            default: raddr = k_reg[AW-1:0];
        endcase
    end

    ppm_seg_mem #(
        .DEPTH (MAX_SEGMENTS),
        .W     (W),
        .AW    (AW)
    ) u_mem (
        .clk    (clk),
        .we     (mem_we),
        .waddr  (in_idx_k[AW-1:0]),
        .wstart (in_start),
        .wend   (in_end),
        .raddr  (raddr),
        .rstart (rstart),
        .rend   (rend)
    );

    // Steer the shared adder
    assign at_target = (act_reg == ACT_L2G) && (k_reg == idx_reg);

    always_comb
    begin
        unique case (state_reg)
            S_SPAN:
            begin
                alu_op = ALU_SUB;
                alu_a  = at_target ? param_reg : rend;
                alu_b  = rstart;
            end
            S_SUM:
            begin
                alu_op = ALU_ADD;
                alu_a  = offset_reg;
                alu_b  = span_reg;
            end
            S_DIFF:
            begin
                alu_op = ALU_SUB;
                alu_a  = param_reg;
                alu_b  = offset_reg;
            end
            S_MAP:
            begin
                alu_op = ALU_ADD;
                alu_a  = (act_reg == ACT_G2L) ? start_reg : offset_reg;
                alu_b  = tmp_reg;
            end
            default:
            begin
                alu_op = ALU_ADD;
                alu_a  = offset_reg;
                alu_b  = span_reg;
            end
        endcase
    end

    ppm_sat_alu #(
        .W (W)
    ) u_alu (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y)
    );

    // Window test of a global to local walk
    assign hit = ($signed(param_reg) <= $signed(alu_y)) || (k_inc == cnt_reg);

    // Sequencer, working registers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            act_reg        <= ACT_LOAD;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            k_reg          <= '0;
            param_reg      <= '0;
            offset_reg     <= '0;
            span_reg       <= '0;
            start_reg      <= '0;
            tmp_reg        <= '0;
            res_mapped_reg <= '0;
            res_seg_reg    <= '0;
            res_status_reg <= ST_OK;
            out_valid_reg  <= 1'b0;
            out_mapped_reg <= '0;
            out_seg_reg    <= '0;
            out_status_reg <= ST_OK;
        end
        else
        begin
            // Drop the result once taken, unless a new one replaces it
            if (out_valid_reg && m_tready && (state_reg != S_OUT))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        act_reg    <= s_tuser;
                        idx_reg    <= in_idx_k;
                        cnt_reg    <= active_cnt;
                        param_reg  <= in_param;
                        k_reg      <= '0;
                        offset_reg <= '0;
                        unique case (s_tuser)
                            ACT_LOAD:
                            begin
                                res_mapped_reg <= '0;
                                res_seg_reg    <= in_index;
                                res_status_reg <= ST_OK;
                                state_reg      <= S_OUT;
                            end
                            ACT_G2L:
                            begin
                                res_seg_reg <= '0;
                                if (active_cnt == '0)
                                begin
                                    res_mapped_reg <= in_param;
                                    res_status_reg <= ST_EMPTY;
                                    state_reg      <= S_OUT;
                                end
                                else
                                begin
                                    res_mapped_reg <= '0;
                                    res_status_reg <= ST_OK;
                                    state_reg      <= S_SPAN;
                                end
                            end
                            ACT_L2G:
                            begin
                                res_mapped_reg <= '0;
                                res_seg_reg    <= '0;
                                if (in_idx_k >= active_cnt)
                                begin
                                    res_status_reg <= ST_RANGE;
                                    state_reg      <= S_OUT;
                                end
                                else
                                begin
                                    res_status_reg <= ST_OK;
                                    state_reg      <= S_SPAN;
                                end
                            end
                            default:
                            begin
                                res_mapped_reg <= '0;
                                res_seg_reg    <= '0;
                                res_status_reg <= ST_OK;
                                state_reg      <= S_OUT;
                            end
                        endcase
                    end
                end
                S_SPAN:
                begin
                    if (at_target)
                    begin
                        tmp_reg   <= alu_y;
                        state_reg <= S_MAP;
                    end
                    else
                    begin
                        span_reg  <= alu_y;
                        start_reg <= rstart;
                        state_reg <= S_SUM;
                    end
                end
                S_SUM:
                begin
                    if ((act_reg == ACT_G2L) && hit)
                    begin
                        res_seg_reg <= k_reg[INDEX_BITS-1:0];
                        state_reg   <= S_DIFF;
                    end
                    else
                    begin
                        offset_reg <= alu_y;
                        k_reg      <= k_inc;
                        state_reg  <= S_SPAN;
                    end
                end
                S_DIFF:
                begin
                    tmp_reg   <= alu_y;
                    state_reg <= S_MAP;
                end
                S_MAP:
                begin
                    res_mapped_reg <= alu_y;
                    state_reg      <= S_OUT;
                end
                S_OUT:
                begin
                    // Hold until the output register is free
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_mapped_reg <= clamp_out(res_mapped_reg);
                        out_seg_reg    <= res_seg_reg;
                        out_status_reg <= res_status_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cfg_write && (paddr == REG_SEGMENT_COUNT))
            count_reg <= pwdata[COUNT_BITS-1:0];
    end

    assign prdata = (paddr == REG_SEGMENT_COUNT) ? {{(32-COUNT_BITS){1'b0}}, count_reg} : '0;

    // Result stream
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_seg_reg, out_mapped_reg};
    assign m_tuser  = out_status_reg;

endmodule

@@ src/ppm_sat_alu.sv @@
// ============================================================================
// ppm_sat_alu
// Shared saturating add/subtract unit over signed values of W bits.
// ============================================================================
module ppm_sat_alu
    import ppm_pkg::*;
#(
    parameter int W = 32
)
(
    input  alu_op_t      op,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic [W-1:0] y
);

    logic [W:0] a_ext;
    logic [W:0] b_ext;
    logic [W:0] sum;

    // Compute one guard bit wider, then clamp on overflow
    assign a_ext = {a[W-1], a};
    assign b_ext = {b[W-1], b};

    always_comb
    begin
        unique case (op)
            ALU_ADD: sum = a_ext + b_ext;
            ALU_SUB: sum = a_ext - b_ext;
            default: sum = a_ext + b_ext;
        endcase
    end

    always_comb
    begin
        if (sum[W] != sum[W-1])
        begin
            y = sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
        else
        begin
            y = sum[W-1:0];
        end
    end

endmodule

@@ src/ppm_seg_mem.sv @@
// ============================================================================
// ppm_seg_mem
// Segment domain table: one write port, one read port with registered data.
// ============================================================================
module ppm_seg_mem
    import ppm_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int W     = 32,
    parameter int AW    = 4
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wstart,
    input  logic [W-1:0]  wend,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rstart,
    output logic [W-1:0]  rend
);

    logic [W-1:0] start_mem [DEPTH];
    logic [W-1:0] end_mem   [DEPTH];

    // Write a loaded segment
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            start_mem[waddr] <= wstart;
            end_mem[waddr]   <= wend;
        end
    end

    // Registered read of one segment
    always_ff @(posedge clk)
    begin
        rstart <= start_mem[raddr];
        rend   <= end_mem[raddr];
    end

endmodule

@@ test/tb_piecewise_parameter_mapper_core.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_piecewise_parameter_mapper_core
// Self-checking bench for the piecewise segment parameter mapper.
// ============================================================================
// Segments are loaded over the request stream and segment_count is set over
// APB between phases, always with the block idle. A directed opening covers
// empty tables, out-of-range indexes, the unused action and saturating
// domains. Random phases then mix loads with queries aimed at window edges
// and segment starts. Each accepted request runs through a local saturating
// model of the segment table. Each result is checked field by field, in
// order, against that model. Both streams idle and stall at random.
// ============================================================================
module tb_piecewise_parameter_mapper_core;
    import ppm_pkg::*;

    localparam int MAX_SEG      = 16;
    localparam int CYCLE_LIMIT  = 600000;
    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam longint Q_MAX    = 64'sd2147483647;
    localparam longint Q_MIN    = -64'sd2147483648;

    typedef struct {
        logic [1:0]         action;
        logic [3:0]         index;
        logic signed [31:0] param;
        logic signed [31:0] dstart;
        logic signed [31:0] dend;
    } map_req_t;

    typedef struct {
        logic signed [31:0] value;
        logic [3:0]         segnum;
        logic [1:0]         status;
    } map_result_t;

    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [103:0] s_tdata  = '0;   // segment_index[3:0], param_value[35:4],
                                   // domain_start[67:36], domain_end[99:68], zero
    logic [1:0]   s_tuser  = '0;   // action[1:0]
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [39:0]  m_tdata;         // mapped_value[31:0], segment_number[35:32], zero
    logic [1:0]   m_tuser;         // status[1:0]
    logic         psel     = 1'b0;
    logic         penable  = 1'b0;
    logic         pwrite   = 1'b0;
    logic [1:0]   paddr    = '0;
    logic [31:0]  pwdata   = '0;
    logic [31:0]  prdata;
    logic         pready;

    // Local copy of the segment table and register
    logic signed [31:0] tbl_start [MAX_SEG];
    logic signed [31:0] tbl_end [MAX_SEG];
    int unsigned        cfg_segments = 0;

    map_req_t    pending_reqs [$];
    map_result_t mapped_expect [$];
    map_req_t    cur_req;

    int     send_gap = 0;
    int     recv_gap = 0;
    bit     steady   = 1'b0;
    int     error_count = 0;
    int     result_count = 0;
    longint cycle_count = 0;
    int     action_seen [4] = '{0, 0, 0, 0};
    int     status_seen [4] = '{0, 0, 0, 0};

    piecewise_parameter_mapper_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    // Saturating arithmetic on the signed 32-bit range
    function automatic longint clamp32(input longint v);
        if (v > Q_MAX)
            return Q_MAX;
        if (v < Q_MIN)
            return Q_MIN;
        return v;
    endfunction

    function automatic longint seg_span(input int k);
        return clamp32(longint'(tbl_end[k]) - longint'(tbl_start[k]));
    endfunction

    function automatic int unsigned active_segments();
        return (cfg_segments > MAX_SEG) ? MAX_SEG : cfg_segments;
    endfunction

    // Global parameter at which the window of segment k ends
    function automatic longint window_end(input int k);
        longint offset;
        offset = 0;
        for (int j = 0; j <= k; j++)
            offset = clamp32(offset + seg_span(j));
        return offset;
    endfunction

    // Apply one request to the local table and compute its result
    function automatic map_result_t map_request(input map_req_t r);
        map_result_t res;
        int unsigned active;
        longint      offset;
        longint      span;
        bit          done;
        res.value  = '0;
        res.segnum = '0;
        res.status = ST_OK;
        active = active_segments();
        offset = 0;
        done   = 1'b0;
        case (r.action)
            ACT_LOAD:
            begin
                tbl_start[r.index] = r.dstart;
                tbl_end[r.index]   = r.dend;
                res.segnum         = r.index;
            end
            ACT_G2L:
            begin
                if (active == 0)
                begin
                    res.value  = r.param;
                    res.status = ST_EMPTY;
                end
                else
                begin
                    for (int k = 0; k < active; k++)
                    begin
                        if (!done)
                        begin
                            span = seg_span(k);
                            if (longint'(r.param) <= clamp32(offset + span) || k == active - 1)
                            begin
                                done       = 1'b1;
                                res.segnum = k[3:0];
                                res.value  = 32'(clamp32(longint'(tbl_start[k])
                                             + clamp32(longint'(r.param) - offset)));
                            end
                            else
                                offset = clamp32(offset + span);
                        end
                    end
                end
            end
            ACT_L2G:
            begin
                if (r.index >= active)
                    res.status = ST_RANGE;
                else
                begin
                    for (int k = 0; k < r.index; k++)
                        offset = clamp32(offset + seg_span(k));
                    res.value = 32'(clamp32(offset
                                + clamp32(longint'(r.param) - longint'(tbl_start[r.index]))));
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Mostly short gaps, some longer ones, none in steady stretches
    function automatic int pick_gap();
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [31:0] random_q16();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 32'(Q_MIN);
        if (r == 1)
            return 32'(Q_MAX);
        if (r < 5)
            return $urandom;
        return 32'(longint'($urandom_range(0, 2 ** 25)) - 2 ** 24);
    endfunction

    function automatic logic signed [31:0] random_end(input logic signed [31:0] first);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return 32'(clamp32(longint'(first) + longint'($urandom_range(0, 2 ** 20))));
        if (r == 7)
            return 32'(clamp32(longint'(first) - longint'($urandom_range(1, 2 ** 20))));
        if (r == 8)
            return first;
        return $urandom;
    endfunction

    // Random request, biased toward window edges and segment starts
    function automatic map_req_t random_request();
        map_req_t    r;
        int unsigned pick;
        int unsigned mode;
        int unsigned active;
        active   = active_segments();
        r.index  = 4'($urandom_range(0, 15));
        r.param  = $urandom;
        r.dstart = $urandom;
        r.dend   = $urandom;
        pick     = $urandom_range(0, 99);
        mode     = $urandom_range(0, 3);
        if (pick < 15)
        begin
            r.action = ACT_LOAD;
            r.dstart = random_q16();
            r.dend   = random_end(r.dstart);
        end
        else if (pick < 60)
        begin
            r.action = ACT_G2L;
            if (active > 0 && mode < 2)
                r.param = 32'(clamp32(window_end($urandom_range(0, active - 1))
                          + longint'($urandom_range(0, 2)) - 1));
            else if (mode == 2)
                r.param = random_q16();
        end
        else if (pick < 98)
        begin
            r.action = ACT_L2G;
            if (active > 0 && mode != 0)
                r.index = 4'($urandom_range(0, active - 1));
            if (mode < 2)
                r.param = 32'(clamp32(longint'(tbl_start[r.index])
                          + longint'($urandom_range(0, 2 ** 17)) - 2 ** 16));
        end
        else
            r.action = ACT_NONE;
        return r;
    endfunction

    function automatic map_req_t make_req(input logic [1:0] action, input logic [3:0] index,
                                          input longint param, input longint dstart,
                                          input longint dend);
        map_req_t r;
        r.action = action;
        r.index  = index;
        r.param  = 32'(param);
        r.dstart = 32'(dstart);
        r.dend   = 32'(dend);
        return r;
    endfunction

    // Append a request to the driver queue
    task automatic enqueue_req(input map_req_t r);
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        $display("MISMATCH %s: got %0d expected %0d (result %0d)",
                 what, got, want, result_count);
    endtask

    // APB write: setup cycle, then access cycle
    task automatic apb_write(input logic [1:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == REG_SEGMENT_COUNT)
            cfg_segments = data[COUNT_BITS-1:0];
    endtask

    // Hold until every queued request has been answered
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || s_tvalid || mapped_expect.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Request driver: predict on acceptance, then present the next request
    always @(posedge clk)
    begin
        map_result_t predicted;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predicted = map_request(cur_req);
                mapped_expect.insert(mapped_expect.size(), predicted);
                action_seen[cur_req.action]++;
                if ($urandom_range(0, 63) == 0)
                    steady = ~steady;
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    cur_req = pending_reqs.pop_front();
                    s_tdata <= {4'b0, cur_req.dend, cur_req.dstart, cur_req.param,
                                cur_req.index};
                    s_tuser <= cur_req.action;
                    s_tvalid <= 1'b1;
                    send_gap = pick_gap();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor: check in order, stall at random
    always @(posedge clk)
    begin
        map_result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                result_count++;
                status_seen[m_tuser]++;
                if (mapped_expect.size() == 0)
                    report_mismatch("result with nothing pending", m_tdata[31:0], 0);
                else
                begin
                    want = mapped_expect.pop_front();
                    if (m_tdata[31:0] !== want.value)
                        report_mismatch("mapped_value", $signed(m_tdata[31:0]), want.value);
                    if (m_tdata[35:32] !== want.segnum)
                        report_mismatch("segment_number", m_tdata[35:32], want.segnum);
                    if (m_tuser !== want.status)
                        report_mismatch("status", m_tuser, want.status);
                end
                recv_gap = pick_gap();
            end
            else if (!m_tvalid && recv_gap == 0 && $urandom_range(0, 15) == 0)
                recv_gap = pick_gap();
            if (recv_gap > 0)
            begin
                recv_gap--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results pending",
                     cycle_count, mapped_expect.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int phase_counts [9];
        int n_items;
        phase_counts = '{16, 1, 2, 0, 15, 8, 16, 5, 0};
        phase_counts[8] = $urandom_range(1, 16);
        for (int k = 0; k < MAX_SEG; k++)
        begin
            tbl_start[k] = '0;
            tbl_end[k]   = '0;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        apb_write(REG_SEGMENT_COUNT, 0);

        // Empty table: echo, range error, unused action, then fill every segment
        enqueue_req(make_req(ACT_G2L, 4'd0, Q_MAX, 0, 0));
        enqueue_req(make_req(ACT_G2L, 4'd15, Q_MIN, Q_MAX, Q_MIN));
        enqueue_req(make_req(ACT_L2G, 4'd0, 12345, 0, 0));
        enqueue_req(make_req(ACT_NONE, 4'd15, -1, -1, -1));
        for (int k = 0; k < MAX_SEG; k++)
        begin
            case (k)
                3:       enqueue_req(make_req(ACT_LOAD, 4'(k), 0, 32'sh30000, 32'sh18000));
                7:       enqueue_req(make_req(ACT_LOAD, 4'(k), 0, 32'sh70000, 32'sh70000));
                14:      enqueue_req(make_req(ACT_LOAD, 4'(k), 0, Q_MIN, Q_MAX));
                15:      enqueue_req(make_req(ACT_LOAD, 4'(k), 0, Q_MAX, Q_MIN));
                default: enqueue_req(make_req(ACT_LOAD, 4'(k), 0, k * 32'sh10000,
                                              k * 32'sh10000 + (k + 1) * 32'sh8000));
            endcase
        end
        wait_idle();

        // Full table: extremes of the parameter and the index
        apb_write(REG_SEGMENT_COUNT, MAX_SEG);
        enqueue_req(make_req(ACT_G2L, 4'd0, Q_MIN, 0, 0));
        enqueue_req(make_req(ACT_G2L, 4'd0, Q_MAX, 0, 0));
        enqueue_req(make_req(ACT_G2L, 4'd0, 0, 0, 0));
        enqueue_req(make_req(ACT_G2L, 4'd0, 32'sh8000, 0, 0));
        enqueue_req(make_req(ACT_L2G, 4'd15, Q_MIN, 0, 0));
        enqueue_req(make_req(ACT_L2G, 4'd0, Q_MAX, 0, 0));
        enqueue_req(make_req(ACT_L2G, 4'd14, 0, 0, 0));
        wait_idle();

        // Random phases over a range of segment counts
        foreach (phase_counts[p])
        begin
            apb_write(REG_SEGMENT_COUNT, phase_counts[p]);
            n_items = (phase_counts[p] == 0) ? 40 : 115;
            for (int i = 0; i < n_items; i++)
                enqueue_req(random_request());
            wait_idle();
        end

        repeat (50) @(posedge clk);
        $display("Requests: %0d loads, %0d global-to-local, %0d local-to-global, %0d unused",
                 action_seen[ACT_LOAD], action_seen[ACT_G2L], action_seen[ACT_L2G],
                 action_seen[ACT_NONE]);
        $display("Results: %0d checked (%0d ok, %0d empty table, %0d out of range), %0d cycles",
                 result_count, status_seen[ST_OK], status_seen[ST_EMPTY],
                 status_seen[ST_RANGE], cycle_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
